/* rtl/urlu_pkg.sv */
package urlu_pkg;

  // character codes
  localparam logic [7:0] CH_PCT   = 8'h25;  // '%'
  localparam logic [7:0] CH_PLUS  = 8'h2B;  // '+'
  localparam logic [7:0] CH_SP    = 8'h20;  // ' '
  localparam logic [7:0] CH_LO_U  = 8'h75;  // 'u'
  localparam logic [7:0] CH_UP_U  = 8'h55;  // 'U'
  localparam logic [7:0] FW_OFFS  = 8'h20;  // full-width to ascii offset
  localparam logic [7:0] FW_LIMIT = 8'h5F;

  localparam int unsigned BUF_DEPTH = 6;
  localparam int unsigned CNT_W     = 3;
  localparam int unsigned MAP_AW    = 16;
  localparam int unsigned MAP_DW    = 9;

  // shift amounts applied to the working buffer
  localparam logic [CNT_W-1:0] SH_ONE  = 3'd1;
  localparam logic [CNT_W-1:0] SH_HEX  = 3'd3;
  localparam logic [CNT_W-1:0] SH_UNI  = 3'd6;

  localparam logic ACT_STREAM = 1'b0;
  localparam logic ACT_MAPWR  = 1'b1;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EVAL,
    ST_MAP
  } state_e;

  typedef struct packed {
    logic take_stream;
    logic take_map;
    logic emit;
    logic emit_map;
    logic clear_en;
  } cmd_t;

  typedef struct packed {
    logic stop;
    logic need_map;
    logic done_after;
    logic out_free;
    logic clr_done;
  } sts_t;

  function automatic logic is_hex(input logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h61 && c <= 8'h66) ||
           (c >= 8'h41 && c <= 8'h46);
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] v;
    if (c >= 8'h61) begin
      v = c - 8'h57;
    end else if (c >= 8'h41) begin
      v = c - 8'h37;
    end else begin
      v = c - 8'h30;
    end
    return v[3:0];
  endfunction

  function automatic logic is_f(input logic [7:0] c);
    return (c == 8'h66) || (c == 8'h46);
  endfunction

endpackage

/* rtl/urlu_in_if.sv */
interface urlu_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [7:0]  data_byte;
  logic        is_last;
  logic [15:0] map_index;
  logic [7:0]  map_byte;
  logic        map_valid;

  modport source (
    output valid, action, data_byte, is_last, map_index, map_byte, map_valid,
    input  ready
  );
  modport sink (
    input  valid, action, data_byte, is_last, map_index, map_byte, map_valid,
    output ready
  );
endinterface

/* rtl/urlu_out_if.sv */
interface urlu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;
  logic       changed;

  modport source (
    output valid, out_byte, out_last, changed,
    input  ready
  );
  modport sink (
    input  valid, out_byte, out_last, changed,
    output ready
  );
endinterface

/* rtl/urlu_ctrl.sv */
module urlu_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_action_i,
  output logic          in_ready_o,
  input  urlu_pkg::sts_t sts_i,
  output urlu_pkg::cmd_t cmd_o
);
  import urlu_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (sts_i.clr_done) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i && in_action_i == ACT_STREAM) state_d = ST_EVAL;
      end
      ST_EVAL: begin
        priority if (sts_i.stop) begin
          state_d = ST_IDLE;
        end else if (sts_i.need_map) begin
          state_d = ST_MAP;
        end else if (sts_i.out_free && sts_i.done_after) begin
          state_d = ST_IDLE;
        end
      end
      ST_MAP: begin
        if (sts_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clear_en = 1'b1;
      end
      ST_IDLE: begin
        in_ready_o         = 1'b1;
        cmd_o.take_stream  = in_valid_i && (in_action_i == ACT_STREAM);
        cmd_o.take_map     = in_valid_i && (in_action_i == ACT_MAPWR);
      end
      ST_EVAL: begin
        cmd_o.emit = !sts_i.stop && !sts_i.need_map && sts_i.out_free;
      end
      ST_MAP: begin
        cmd_o.emit_map = sts_i.out_free;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  a_emit_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.emit || cmd_o.emit_map) |-> sts_i.out_free)
    else $error("emit issued with output register full");

  a_map_after_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MAP) |-> ($past(state_q) == ST_EVAL || $past(state_q) == ST_MAP))
    else $error("map state entered without evaluation");

  a_no_take_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> !in_ready_o)
    else $error("request taken during table clear");

endmodule

/* rtl/urlu_dp.sv */
module urlu_dp (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_wdata_i,
  input  logic [7:0]         data_byte_i,
  input  logic               is_last_i,
  input  logic [15:0]        map_index_i,
  input  logic [7:0]         map_byte_i,
  input  logic               map_valid_i,
  input  urlu_pkg::cmd_t     cmd_i,
  output urlu_pkg::sts_t     sts_o,
  urlu_out_if.source         out_o
);
  import urlu_pkg::*;

  logic [7:0]        buf_q [BUF_DEPTH];
  logic [7:0]        buf_d [BUF_DEPTH];
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              last_q, last_d;
  logic              chg_q, chg_d;
  logic              map_en_q;
  logic [MAP_AW-1:0] clr_q;

  logic [MAP_DW-1:0] mem [2**MAP_AW];
  logic [MAP_DW-1:0] rdata_q;
  logic              mem_we;
  logic [MAP_AW-1:0] mem_waddr;
  logic [MAP_DW-1:0] mem_wdata;
  logic [MAP_AW-1:0] code;

  logic              out_valid_q;
  logic [7:0]        out_byte_q;
  logic              out_last_q;
  logic              changed_q;

  logic [BUF_DEPTH-1:0] hexv;
  logic              ubad;
  logic              dec_stop, dec_need_map, dec_change;
  logic [7:0]        dec_byte;
  logic [CNT_W-1:0]  dec_shift;

  logic [7:0]        uni_low, uni_byte;
  logic              em_any, em_final, em_change;
  logic [7:0]        em_byte;
  logic [CNT_W-1:0]  em_shift;

  // head-of-buffer decision
  always_comb begin
    for (int k = 0; k < BUF_DEPTH; k++) hexv[k] = is_hex(buf_q[k]);
    ubad = 1'b0;
    for (int k = 2; k < BUF_DEPTH; k++) begin
      if (CNT_W'(k) < cnt_q && !hexv[k]) ubad = 1'b1;
    end
    dec_stop     = 1'b0;
    dec_need_map = 1'b0;
    dec_change   = 1'b0;
    dec_byte     = CH_PCT;
    dec_shift    = SH_ONE;
    priority if (buf_q[0] != CH_PCT) begin
      if (buf_q[0] == CH_PLUS) begin
        dec_byte   = CH_SP;
        dec_change = 1'b1;
      end else begin
        dec_byte = buf_q[0];
      end
    end else if (cnt_q < 3'd2) begin
      dec_stop = !last_q;
    end else if (buf_q[1] == CH_LO_U || buf_q[1] == CH_UP_U) begin
      // a bad or truncated %u gives '%' here and the 'u' as a literal next
      if (!ubad && cnt_q == 3'd6) begin
        dec_need_map = 1'b1;
      end else if (!ubad && !last_q) begin
        dec_stop = 1'b1;
      end
    end else if (!hexv[1]) begin
      dec_byte = CH_PCT;
    end else if (cnt_q < 3'd3) begin
      dec_stop = !last_q;
    end else if (hexv[2]) begin
      dec_byte   = {hex_val(buf_q[1]), hex_val(buf_q[2])};
      dec_change = 1'b1;
      dec_shift  = SH_HEX;
    end else begin
      dec_byte = CH_PCT;
    end
  end

  // percent-u code point and its byte once the table word is back
  assign code = {hex_val(buf_q[2]), hex_val(buf_q[3]),
                 hex_val(buf_q[4]), hex_val(buf_q[5])};
  assign uni_low = code[7:0];

  always_comb begin
    if (map_en_q && rdata_q[8]) begin
      uni_byte = rdata_q[7:0];
    end else if (uni_low > 8'h00 && uni_low < FW_LIMIT &&
                 is_f(buf_q[2]) && is_f(buf_q[3])) begin
      uni_byte = uni_low + FW_OFFS;
    end else begin
      uni_byte = uni_low;
    end
  end

  assign em_any    = cmd_i.emit || cmd_i.emit_map;
  assign em_byte   = cmd_i.emit_map ? uni_byte : dec_byte;
  assign em_change = cmd_i.emit_map || dec_change;
  assign em_shift  = cmd_i.emit_map ? SH_UNI : dec_shift;
  assign em_final  = last_q && (cnt_q == em_shift);

  // buffer, count and string flags
  always_comb begin
    buf_d  = buf_q;
    cnt_d  = cnt_q;
    last_d = last_q;
    chg_d  = chg_q;
    if (cmd_i.take_stream) begin
      buf_d[cnt_q] = data_byte_i;
      cnt_d        = cnt_q + 3'd1;
      last_d       = is_last_i;
    end
    if (em_any) begin
      unique case (em_shift)
        SH_ONE: for (int i = 0; i < BUF_DEPTH - 1; i++) buf_d[i] = buf_q[i+1];
        SH_HEX: for (int i = 0; i < BUF_DEPTH - 3; i++) buf_d[i] = buf_q[i+3];
        default: buf_d = buf_q;
      endcase
      cnt_d = cnt_q - em_shift;
      if (em_final) begin
        last_d = 1'b0;
        chg_d  = 1'b0;
      end else begin
        chg_d = chg_q || em_change;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q <= buf_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      last_q   <= 1'b0;
      chg_q    <= 1'b0;
      map_en_q <= 1'b0;
      clr_q    <= '0;
    end else begin
      cnt_q  <= cnt_d;
      last_q <= last_d;
      chg_q  <= chg_d;
      if (cfg_we_i) map_en_q <= cfg_wdata_i;
      if (cmd_i.clear_en) clr_q <= clr_q + MAP_AW'(1);
    end
  end

  // map table
  assign mem_we    = cmd_i.clear_en || cmd_i.take_map;
  assign mem_waddr = cmd_i.clear_en ? clr_q : map_index_i;
  assign mem_wdata = cmd_i.clear_en ? '0 : {map_valid_i, map_byte_i};

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rdata_q <= mem[code];
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (em_any) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (em_any) begin
      out_byte_q <= em_byte;
      out_last_q <= em_final;
      changed_q  <= em_final && (chg_q || em_change);
    end
  end

  assign out_o.valid    = out_valid_q;
  assign out_o.out_byte = out_byte_q;
  assign out_o.out_last = out_last_q;
  assign out_o.changed  = changed_q;

  assign sts_o.stop       = dec_stop;
  assign sts_o.need_map   = dec_need_map;
  assign sts_o.done_after = (cnt_q == dec_shift);
  assign sts_o.out_free   = !out_valid_q || out_o.ready;
  assign sts_o.clr_done   = (clr_q == '1);

  a_last_has_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_q |-> (cnt_q != '0))
    else $error("string end pending with empty buffer");

  a_room_on_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.take_stream |-> (cnt_q < 3'd6) && !last_q)
    else $error("byte taken into a full or closing buffer");

  a_changed_only_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    em_any && !em_final |=> !changed_q)
    else $error("changed flag set on a non-final byte");

endmodule

/* rtl/url_percent_u_decoder.sv */
// streaming url decoder with %uXXXX escapes. raw bytes come in one request at a
// time on in_i (action 0, is_last on the final byte of a string) and decoded
// bytes leave on out_o, the last one flagged with out_last, and with changed
// when the string was altered. '+' gives a space, %XX its byte, %uXXXX either
// the byte from the 64k-entry map table (when map_enable is set and the entry
// is valid) or its low byte, moved down into ascii for full-width codes.
// action 1 writes one map table entry. after reset the map table is swept to
// unmapped, one entry a cycle, so in_i.ready stays low until the sweep ends;
// map_enable may be written meanwhile. a stream byte is taken while idle, then
// evaluation releases one decoded byte per cycle while the output register has
// room, going back to idle once the buffer is empty or holds only an undecided
// escape; a %u decode adds a registered map table read. output bytes go through
// a one-entry output register, so a stalled sink holds the decode sequencer
module url_percent_u_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  urlu_in_if.sink     in_i,
  urlu_out_if.source  out_o
);
  import urlu_pkg::*;

  cmd_t cmd;
  sts_t sts;
  logic in_ready;

  // sequencer: clear sweep, request intake, head-of-buffer evaluation, map table read
  urlu_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_action_i (in_i.action),
    .in_ready_o  (in_ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  assign in_i.ready = in_ready;

  // working buffer, map table memory and output register
  urlu_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .data_byte_i (in_i.data_byte),
    .is_last_i   (in_i.is_last),
    .map_index_i (in_i.map_index),
    .map_byte_i  (in_i.map_byte),
    .map_valid_i (in_i.map_valid),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_o       (out_o)
  );

endmodule
